>>> hw/rtl/fpa_pkg.sv
// shared types and constants of the q24.8 fixed-point alu
package fpa_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned FractBits = 8;
  // dividend width of the rounding divide: 2 * (|a| << fract) + |b|
  localparam int unsigned DivBits   = WordBits + FractBits + 1;

  // operation codes
  typedef enum logic [3:0] {
    KIND_ADD     = 4'd0,
    KIND_SUB     = 4'd1,
    KIND_MUL     = 4'd2,
    KIND_DIV     = 4'd3,
    KIND_MIN     = 4'd4,
    KIND_MAX     = 4'd5,
    KIND_INC     = 4'd6,
    KIND_DEC     = 4'd7,
    KIND_CMP     = 4'd8,
    KIND_FROM_INT = 4'd9,
    KIND_TO_INT  = 4'd10
  } kind_e;

  localparam logic [3:0] KindLast = 4'd10;

  // compare outcome codes
  localparam logic [1:0] OrderLt = 2'd0;
  localparam logic [1:0] OrderEq = 2'd1;
  localparam logic [1:0] OrderGt = 2'd2;

  // status codes
  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatSat  = 2'd1;
  localparam logic [1:0] StatDiv0 = 2'd2;

  // classified request between front and back
  typedef struct packed {
    kind_e                      kind;
    logic                       unused;
    logic signed [WordBits-1:0] a;
    logic signed [WordBits-1:0] b;
    logic [WordBits-1:0]        a_mag;
    logic [WordBits-1:0]        b_mag;
    logic                       a_neg;
    logic                       b_neg;
    logic                       b_zero;
    logic                       lt;
    logic                       eq;
  } fpa_req_t;

endpackage

>>> hw/rtl/fpa_front.sv
// front end: decodes and classifies each request before queuing
module fpa_front (
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [3:0]                           kind_i,
  input  logic signed [fpa_pkg::WordBits-1:0]  operand_a_i,
  input  logic signed [fpa_pkg::WordBits-1:0]  operand_b_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output fpa_pkg::fpa_req_t                    req_o
);
  import fpa_pkg::*;

  // accept whenever the queue has room
  assign in_ready_o = ~full_i;
  assign push_o     = in_valid_i & ~full_i;

  // classification: op decode, signs, magnitudes, comparisons
  always_comb begin
    req_o.unused = (kind_i > KindLast);
    req_o.kind   = req_o.unused ? KIND_ADD : kind_e'(kind_i);
    req_o.a      = operand_a_i;
    req_o.b      = operand_b_i;
    req_o.a_neg  = operand_a_i[WordBits-1];
    req_o.b_neg  = operand_b_i[WordBits-1];
    req_o.a_mag  = req_o.a_neg ? (WordBits'(0) - WordBits'(operand_a_i))
                               : WordBits'(operand_a_i);
    req_o.b_mag  = req_o.b_neg ? (WordBits'(0) - WordBits'(operand_b_i))
                               : WordBits'(operand_b_i);
    req_o.b_zero = (operand_b_i == '0);
    req_o.lt     = (operand_a_i < operand_b_i);
    req_o.eq     = (operand_a_i == operand_b_i);
  end

endmodule

>>> hw/rtl/fpa_queue.sv
// two-entry request queue between front and back
module fpa_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fpa_pkg::fpa_req_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output fpa_pkg::fpa_req_t rdata_o,
  output logic              empty_o
);
  import fpa_pkg::*;

  fpa_req_t   mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

endmodule

>>> hw/rtl/fpa_back.sv
// back end: execution pipeline with bit-per-stage rounding divider
module fpa_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fpa_pkg::fpa_req_t                    req_i,
  input  logic                                 req_valid_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [fpa_pkg::WordBits-1:0]  result_value_o,
  output logic [1:0]                           order_o,
  output logic [1:0]                           status_o
);
  import fpa_pkg::*;

  typedef enum logic [1:0] {
    FIN_DIRECT,
    FIN_MUL,
    FIN_DIV
  } fin_e;

  typedef struct packed {
    fin_e                         fin;
    logic signed [WordBits-1:0]   res;
    logic [1:0]                   ord;
    logic [1:0]                   stat;
    logic                         neg;
    logic signed [2*WordBits-1:0] prod;
    logic [WordBits-1:0]          rem;
    logic [DivBits-1:0]           nq;
    logic [WordBits:0]            den;
  } stage_t;

  localparam logic signed [WordBits-1:0] WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits-1:0] WordMin = {1'b1, {(WordBits-1){1'b0}}};

  // clamp a WordBits+1 signed sum into the word
  function automatic logic [WordBits+1:0] clamp_sum(input logic [WordBits:0] s);
    logic [WordBits+1:0] r;
    if (s[WordBits] != s[WordBits-1]) begin
      r = {(s[WordBits] ? WordMin : WordMax), StatSat};
    end else begin
      r = {s[WordBits-1:0], StatOk};
    end
    return r;
  endfunction

  // apply sign to a magnitude and clamp into the word
  function automatic logic [WordBits+1:0] clamp_mag(input logic neg,
                                                     input logic [2*WordBits-1:0] m);
    logic [WordBits+1:0] r;
    if (neg) begin
      if (m > (2*WordBits)'(WordMin[WordBits-1:0])) r = {WordMin, StatSat};
      else r = {WordBits'(0) - m[WordBits-1:0], StatOk};
    end else begin
      if (m > (2*WordBits)'(WordMax)) r = {WordMax, StatSat};
      else r = {m[WordBits-1:0], StatOk};
    end
    return r;
  endfunction

  // one restoring divide step
  function automatic stage_t div_step(input stage_t s);
    stage_t              o;
    logic [WordBits:0]   r2;
    logic                qb;
    o  = s;
    r2 = {s.rem, s.nq[DivBits-1]};
    qb = (r2 >= s.den);
    if (qb) r2 = r2 - s.den;
    o.rem = r2[WordBits-1:0];
    o.nq  = {s.nq[DivBits-2:0], qb};
    return o;
  endfunction

  stage_t              stg_q [DivBits+1];
  logic [DivBits:0]    vld_q;
  stage_t              ent;
  logic                en;
  logic                out_valid_q;
  logic signed [WordBits-1:0] res_q;
  logic [1:0]          ord_q, stat_q;
  logic [WordBits+1:0] fin_r;

  // whole pipeline moves when the output register can take a result
  assign en    = ~out_valid_q | out_ready_i;
  assign pop_o = en & req_valid_i;

  // entry stage: simple ops finish here, mul and div are set up
  always_comb begin
    logic [WordBits:0]   s;
    logic [WordBits:0]   t;
    logic [WordBits+1:0] c;
    ent       = '0;
    ent.fin   = FIN_DIRECT;
    ent.neg   = req_i.a_neg ^ req_i.b_neg;
    ent.prod  = req_i.a * req_i.b;
    ent.rem   = '0;
    ent.nq    = ({1'b0, req_i.a_mag, {FractBits{1'b0}}} << 1) + DivBits'(req_i.b_mag);
    ent.den   = {req_i.b_mag, 1'b0};
    s = '0;
    t = '0;
    c = '0;
    if (!req_i.unused) begin
      unique case (req_i.kind)
        KIND_ADD, KIND_SUB, KIND_INC, KIND_DEC: begin
          unique case (req_i.kind)
            KIND_ADD: s = {req_i.a[WordBits-1], req_i.a} + {req_i.b[WordBits-1], req_i.b};
            KIND_SUB: s = {req_i.a[WordBits-1], req_i.a} - {req_i.b[WordBits-1], req_i.b};
            KIND_INC: s = {req_i.a[WordBits-1], req_i.a} + (WordBits+1)'(1);
            default:  s = {req_i.a[WordBits-1], req_i.a} - (WordBits+1)'(1);
          endcase
          c        = clamp_sum(s);
          ent.res  = c[WordBits+1:2];
          ent.stat = c[1:0];
        end
        KIND_MUL: ent.fin = FIN_MUL;
        KIND_DIV: begin
          if (req_i.b_zero) begin
            ent.stat = StatDiv0;
            ent.res  = req_i.a_neg ? WordMin : WordMax;
          end else begin
            ent.fin = FIN_DIV;
          end
        end
        KIND_MIN: ent.res = req_i.lt ? req_i.a : req_i.b;
        KIND_MAX: ent.res = (req_i.lt || req_i.eq) ? req_i.b : req_i.a;
        KIND_CMP: ent.ord = req_i.lt ? OrderLt : (req_i.eq ? OrderEq : OrderGt);
        KIND_FROM_INT: begin
          if ((&req_i.a[WordBits-1 -: FractBits+1]) || ~(|req_i.a[WordBits-1 -: FractBits+1]))
          begin
            ent.res = req_i.a <<< FractBits;
          end else begin
            ent.res  = req_i.a_neg ? WordMin : WordMax;
            ent.stat = StatSat;
          end
        end
        KIND_TO_INT: begin
          t = ({1'b0, req_i.a_mag} + (WordBits+1)'(1 << (FractBits-1))) >> FractBits;
          ent.res = req_i.a_neg ? (WordBits'(0) - t[WordBits-1:0]) : t[WordBits-1:0];
        end
        default: ent.res = '0;
      endcase
    end
  end

  // final rounding and saturation of mul and div
  always_comb begin
    logic [2*WordBits-1:0] m;
    m     = stg_q[DivBits].prod[2*WordBits-1] ? ((2*WordBits)'(0) - stg_q[DivBits].prod)
                                              : stg_q[DivBits].prod;
    m     = (m + (2*WordBits)'(1 << (FractBits-1))) >> FractBits;
    fin_r = {stg_q[DivBits].res, stg_q[DivBits].stat};
    unique case (stg_q[DivBits].fin)
      FIN_MUL: fin_r = clamp_mag(stg_q[DivBits].prod[2*WordBits-1], m);
      FIN_DIV: fin_r = clamp_mag(stg_q[DivBits].neg,
                                 {{(2*WordBits-DivBits){1'b0}}, stg_q[DivBits].nq});
      default: fin_r = {stg_q[DivBits].res, stg_q[DivBits].stat};
    endcase
  end

  // valid bits of the pipeline and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[DivBits-1:0], req_valid_i};
      out_valid_q <= vld_q[DivBits];
    end
  end

  // payload of the pipeline and output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      stg_q[0] <= ent;
      for (int i = 1; i <= DivBits; i++) begin
        stg_q[i] <= div_step(stg_q[i-1]);
      end
      res_q  <= fin_r[WordBits+1:2];
      stat_q <= fin_r[1:0];
      ord_q  <= stg_q[DivBits].ord;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign order_o        = ord_q;
  assign status_o       = stat_q;

endmodule

>>> hw/rtl/fixed_point_alu_q24_8_unit.sv
// top level of the q24.8 fixed-point alu
// Takes one request per cycle while the output is not stalled and returns one result per
// request, in order. Each request passes through the two-entry request queue, the entry
// stage, the divider pipeline (one quotient bit per stage, which sets the latency of every
// operation) and the output register, in that order. A stalled output holds the whole back
// pipeline; the queue keeps accepting until it fills. Results saturate with status 1,
// divide by zero returns status 2.
module fixed_point_alu_q24_8_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [3:0]                           kind_i,
  input  logic signed [fpa_pkg::WordBits-1:0]  operand_a_i,
  input  logic signed [fpa_pkg::WordBits-1:0]  operand_b_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [fpa_pkg::WordBits-1:0]  result_value_o,
  output logic [1:0]                           order_o,
  output logic [1:0]                           status_o
);
  import fpa_pkg::*;

  fpa_req_t fr_req, q_req;
  logic     push, full, pop, empty;

  // classify requests
  fpa_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .full_i      (full),
    .push_o      (push),
    .req_o       (fr_req)
  );

  // decouple front and back
  fpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (fr_req),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (q_req),
    .empty_o (empty)
  );

  // execute
  fpa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (q_req),
    .req_valid_i    (~empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .order_o        (order_o),
    .status_o       (status_o)
  );

endmodule
